### src/fenwick_tree_2d_rect_sum_assert.svh
// Assertion macros for the 2-D Fenwick tree block.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef FENWICK_TREE_2D_RECT_SUM_ASSERT_SVH
`define FENWICK_TREE_2D_RECT_SUM_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FWT2_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FWT2_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fwt2_pkg.sv
// Shared types and constants of the 2-D Fenwick tree block.
// No dependencies.
package fwt2_pkg;

    // Field widths fixed by the interface
    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int REQ_W  = 2;
    localparam int SIZE_W = 7;

    // Reset value of the size register
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Sequencer to walker command
    typedef struct packed {
        logic start;
        logic add_mode;
    } t_walk_cmd;

    // Walker status back to the sequencer
    typedef struct packed {
        logic active;
        logic last;
    } t_walk_st;

endpackage

### src/fenwick_tree_2d_rect_sum.sv
// A point add walks up to 49 cells on its update path at side 64; a rectangle sum walks
//   the prefix cells of each of its terms.
// Throughput: one item at a time; one store word per cycle during a walk, through the single
//   RAM read port and one shared 32-bit adder, so the time per item tracks the number of cells walked.
// Reset (synchronous, active low) clears control and then sweeps all MAX_SIDE*MAX_SIDE
//   store words to zero, as a clear request also does; no input is taken during the sweep.
`include "fenwick_tree_2d_rect_sum_assert.svh"

module fenwick_tree_2d_rect_sum #(
    parameter int MAX_SIDE = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [fwt2_pkg::REQ_W-1:0]         i_req_type,
    input  logic [fwt2_pkg::IDX_W-1:0]         i_row_lo,
    input  logic [fwt2_pkg::IDX_W-1:0]         i_col_lo,
    input  logic [fwt2_pkg::IDX_W-1:0]         i_row_hi,
    input  logic [fwt2_pkg::IDX_W-1:0]         i_col_hi,
    input  logic signed [fwt2_pkg::DATA_W-1:0] i_add_value,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [fwt2_pkg::DATA_W-1:0] o_rect_sum,
    output logic                               o_out_of_range,
    // size register write
    input  logic                               i_cfg_we,
    input  logic [fwt2_pkg::SIZE_W-1:0]        i_cfg_wdata
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_SIDE) + 1;
    localparam int NW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = (NW > fwt2_pkg::SIZE_W) ? NW : fwt2_pkg::SIZE_W;
    localparam int DW    = fwt2_pkg::DATA_W;

    // Prefix terms of the inclusion-exclusion, named by (row, col) corner
    localparam logic [1:0] TERM_HH = 2'd0;
    localparam logic [1:0] TERM_LH = 2'd1;
    localparam logic [1:0] TERM_HL = 2'd2;
    localparam logic [1:0] TERM_LL = 2'd3;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                         r_state;
    logic [fwt2_pkg::SIZE_W-1:0]    r_size;
    logic [AW-1:0]                  r_sweep_addr;
    logic                           r_mode_add;
    logic [1:0]                     r_term;
    logic                           r_launch;
    logic                           r_oor;
    logic [IW-1:0]                  r_r1, r_c1, r_r2, r_c2;
    logic [DW-1:0]                  r_value;
    logic [DW-1:0]                  r_acc;
    logic                           r_p_valid;
    logic                           r_p_neg;
    logic [AW-1:0]                  r_p_addr;
    logic                           r_out_valid;
    logic [DW-1:0]                  r_rect_sum;
    logic                           r_oor_out;

    logic [CW-1:0]                  w_size_x;
    logic [CW-1:0]                  w_side_c;
    logic [IW-1:0]                  w_side;
    logic                           w_take;
    logic                           w_bad_add;
    logic                           w_bad_query;
    logic                           w_term_ok;
    logic                           w_final_term;
    logic                           w_neg;
    logic                           w_out_free;
    logic [IW-1:0]                  w_term_row, w_term_col;
    fwt2_pkg::t_walk_cmd            w_walk_cmd;
    fwt2_pkg::t_walk_st             w_walk_st;
    logic [AW-1:0]                  w_walk_addr;
    logic [DW-1:0]                  w_rd_data;
    logic [DW-1:0]                  w_op_a, w_op_b, w_sum;
    logic                           w_cin;
    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    logic [DW-1:0]                  w_wdata;

    // Effective side: 0 acts as 1, anything above MAX_SIDE as MAX_SIDE
    assign w_size_x = CW'(r_size);
    assign w_side_c = (w_size_x == '0) ? CW'(1) :
                      (w_size_x > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : w_size_x;
    assign w_side   = IW'(w_side_c);

    // Index range checks against the side in use
    assign w_bad_add   = (CW'(i_row_lo) >= w_side_c) || (CW'(i_col_lo) >= w_side_c);
    assign w_bad_query = w_bad_add || (CW'(i_row_hi) >= w_side_c)
                         || (CW'(i_col_hi) >= w_side_c);

    assign o_in_ready = (r_state == S_IDLE);
    assign w_take     = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Term corner selection; a term whose lower index would be -1 contributes 0
    assign w_term_row   = r_term[0] ? (r_r1 - IW'(1)) : r_r2;
    assign w_term_col   = r_term[1] ? (r_c1 - IW'(1)) : r_c2;
    assign w_neg        = r_term[0] ^ r_term[1];
    assign w_final_term = r_mode_add || (r_term == TERM_LL);
    always_comb begin
        case (r_term)
            TERM_HH: w_term_ok = 1'b1;
            TERM_LH: w_term_ok = (r_r1 != '0);
            TERM_HL: w_term_ok = (r_c1 != '0);
            TERM_LL: w_term_ok = (r_r1 != '0) && (r_c1 != '0);
            default: w_term_ok = 1'b0;
        endcase
    end

    assign w_walk_cmd.start    = (r_state == S_RUN) && r_launch && w_term_ok;
    assign w_walk_cmd.add_mode = r_mode_add;

    fwt2_walk #(
        .MAX_SIDE (MAX_SIDE)
    ) u_walk (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_walk_cmd),
        .i_row  (w_term_row),
        .i_col  (w_term_col),
        .i_side (w_side),
        .o_st   (w_walk_st),
        .o_addr (w_walk_addr)
    );

    // Shared adder: read-modify-write for point add, signed accumulate for sums
    assign w_op_a = r_mode_add ? w_rd_data : r_acc;
    assign w_op_b = r_mode_add ? r_value : (r_p_neg ? ~w_rd_data : w_rd_data);
    assign w_cin  = !r_mode_add && r_p_neg;
    assign w_sum  = w_op_a + w_op_b + DW'(w_cin);

    // Store write port: clearing sweep or add write-back
    assign w_we    = (r_state == S_SWEEP) || (r_p_valid && r_mode_add);
    assign w_waddr = (r_state == S_SWEEP) ? r_sweep_addr : r_p_addr;
    assign w_wdata = (r_state == S_SWEEP) ? '0 : w_sum;

    fwt2_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_walk_addr),
        .o_rdata(w_rd_data)
    );

    // Request payload capture and accumulator
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_r1    <= IW'(i_row_lo);
            r_c1    <= IW'(i_col_lo);
            r_value <= i_add_value;
            r_acc   <= '0;
            if (i_req_type == fwt2_pkg::REQ_ADD) begin
                r_r2 <= IW'(i_row_lo);
                r_c2 <= IW'(i_col_lo);
            end else begin
                r_r2 <= IW'(i_row_hi);
                r_c2 <= IW'(i_col_hi);
            end
        end else if (r_p_valid && !r_mode_add) begin
            r_acc <= w_sum;
        end
        r_p_addr <= w_walk_addr;
        r_p_neg  <= w_neg;
    end

    // Sequencer, size register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_size       <= fwt2_pkg::SIZE_RESET;
            r_sweep_addr <= '0;
            r_mode_add   <= 1'b0;
            r_term       <= TERM_HH;
            r_launch     <= 1'b0;
            r_oor        <= 1'b0;
            r_p_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_rect_sum   <= '0;
            r_oor_out    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            r_p_valid <= w_walk_st.active;
            // output transfer empties the result register; the done state refills it
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    r_sweep_addr <= r_sweep_addr + AW'(1);
                    if (r_sweep_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_take) begin
                        r_term       <= TERM_HH;
                        r_launch     <= 1'b1;
                        r_sweep_addr <= '0;
                        case (i_req_type)
                            fwt2_pkg::REQ_CLEAR: begin
                                r_state <= S_SWEEP;
                            end
                            fwt2_pkg::REQ_ADD: begin
                                r_mode_add <= 1'b1;
                                r_oor      <= w_bad_add;
                                r_state    <= w_bad_add ? S_DONE : S_RUN;
                            end
                            fwt2_pkg::REQ_QUERY: begin
                                r_mode_add <= 1'b0;
                                r_oor      <= w_bad_query;
                                r_state    <= w_bad_query ? S_DONE : S_RUN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (r_launch) begin
                        if (w_term_ok) begin
                            r_launch <= 1'b0;
                        end else if (w_final_term) begin
                            r_launch <= 1'b0;
                            r_state  <= S_DRAIN;
                        end else begin
                            r_term <= r_term + 2'd1;
                        end
                    end else if (w_walk_st.active && w_walk_st.last) begin
                        if (w_final_term) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_term   <= r_term + 2'd1;
                            r_launch <= 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    // the last read, if one is still in flight, lands in the adder this cycle
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_rect_sum  <= r_acc;
                        r_oor_out   <= r_oor;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rect_sum     = r_rect_sum;
    assign o_out_of_range = r_oor_out;

    // Checks
    `FWT2_ASSERT_IMP(a_walk_only_in_run, w_walk_st.active, r_state == S_RUN, "walker active outside run")
    `FWT2_ASSERT_IMP(a_no_sweep_overlap, r_p_valid, r_state != S_SWEEP, "store access during sweep")
    `FWT2_ASSERT_IMP(a_oor_sum_zero, r_out_valid && r_oor_out, r_rect_sum == '0, "flagged result not zero")
    `FWT2_ASSERT_NXT(a_busy_after_take, w_take && (i_req_type != fwt2_pkg::REQ_UNUSED), !o_in_ready, "ready right after a taken request")

endmodule

### src/fwt2_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fwt2_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/fwt2_walk.sv
// Two-level index walker: emits one store address per cycle along a Fenwick path.
// Depends on fwt2_pkg (walker command and status structs).
module fwt2_walk #(
    parameter  int MAX_SIDE = 64,
    localparam int IW       = $clog2(MAX_SIDE) + 1,
    localparam int AW       = $clog2(MAX_SIDE * MAX_SIDE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fwt2_pkg::t_walk_cmd i_cmd,
    input  logic [IW-1:0]       i_row,
    input  logic [IW-1:0]       i_col,
    input  logic [IW-1:0]       i_side,
    output fwt2_pkg::t_walk_st  o_st,
    output logic [AW-1:0]       o_addr
);

    logic          r_busy;
    logic          r_add;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_j0;

    logic [IW-1:0] w_i_inc, w_i_and, w_i_or, w_i_next;
    logic [IW-1:0] w_j_inc, w_j_and, w_j_or, w_j_next;
    logic          w_i_end, w_j_end;

    // Update walk goes up by i | (i + 1), prefix walk goes down by (i & (i + 1)) - 1
    assign w_i_inc  = r_i + IW'(1);
    assign w_i_and  = r_i & w_i_inc;
    assign w_i_or   = r_i | w_i_inc;
    assign w_i_next = r_add ? w_i_or : (w_i_and - IW'(1));
    assign w_i_end  = r_add ? (w_i_or >= i_side) : (w_i_and == '0);

    assign w_j_inc  = r_j + IW'(1);
    assign w_j_and  = r_j & w_j_inc;
    assign w_j_or   = r_j | w_j_inc;
    assign w_j_next = r_add ? w_j_or : (w_j_and - IW'(1));
    assign w_j_end  = r_add ? (w_j_or >= i_side) : (w_j_and == '0);

    assign o_st.active = r_busy;
    assign o_st.last   = w_i_end & w_j_end;

    // Row-major store address; both indices are below MAX_SIDE while busy
    assign o_addr = AW'(r_i[IW-2:0]) * AW'(MAX_SIDE) + AW'(r_j[IW-2:0]);

    // Walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && w_j_end && w_i_end) begin
            r_busy <= 1'b0;
        end
    end

    // Index registers: inner index restarts from its origin at each outer step
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_add <= i_cmd.add_mode;
            r_i   <= i_row;
            r_j   <= i_col;
            r_j0  <= i_col;
        end else if (r_busy) begin
            if (!w_j_end) begin
                r_j <= w_j_next;
            end else if (!w_i_end) begin
                r_i <= w_i_next;
                r_j <= r_j0;
            end
        end
    end

endmodule

### dv/tb_fenwick_tree_2d_rect_sum.sv
// Testbench for the 2-D Fenwick tree rectangle-sum block (fenwick_tree_2d_rect_sum).
// Uses types and request codes from fwt2_pkg. A scoreboard class predicts every
// result from its own copy of the grid; a task drives the input channel, a receiver process the output ready.
`timescale 1ns / 1ps

module tb_fenwick_tree_2d_rect_sum;

    localparam int DATA_W       = fwt2_pkg::DATA_W;
    localparam int IDX_W        = fwt2_pkg::IDX_W;
    localparam int REQ_W        = fwt2_pkg::REQ_W;
    localparam int SIZE_W       = fwt2_pkg::SIZE_W;
    localparam int GRID_MAX     = 64;
    localparam int CLEAR_CYCLES = 4200;     // clear sweep plus margin
    localparam int LONG_HOLD    = 400;      // receiver hold-off, in cycles
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 140;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              oor;
    } t_rect_result;

    // Grid model and queue of pending results
    class rect_sum_scoreboard;
        logic [DATA_W-1:0] cells [GRID_MAX*GRID_MAX];
        logic [SIZE_W-1:0] size_reg;
        t_rect_result      sum_pending_q [$];
        int                errors;

        function new();
            foreach (cells[k]) cells[k] = '0;
            size_reg = fwt2_pkg::SIZE_RESET;
            errors   = 0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] v);
            size_reg = v;
        endfunction

        // Side length in effect: 0 acts as 1, above the maximum clamps
        function int side();
            if (size_reg == 0) return 1;
            if (size_reg > GRID_MAX) return GRID_MAX;
            return int'(size_reg);
        endfunction

        function int pending();
            return sum_pending_q.size();
        endfunction

        // Sum over rows 0..r and cols 0..c, zero when either is negative
        function logic [DATA_W-1:0] prefix_total(int r, int c);
            logic [DATA_W-1:0] acc;
            acc = '0;
            for (int i = r; i >= 0; i = (i & (i + 1)) - 1)
                for (int j = c; j >= 0; j = (j & (j + 1)) - 1)
                    acc += cells[i*GRID_MAX + j];
            return acc;
        endfunction

        // Apply one accepted request and queue the result it causes
        function void note_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] r1,
                                   logic [IDX_W-1:0] c1, logic [IDX_W-1:0] r2,
                                   logic [IDX_W-1:0] c2, logic [DATA_W-1:0] v);
            int n, a, b, c, d;
            t_rect_result res;
            n = side();
            a = int'(r1);
            b = int'(c1);
            c = int'(r2);
            d = int'(c2);
            res.sum = '0;
            res.oor = 1'b0;
            case (req)
                fwt2_pkg::REQ_CLEAR: begin
                    foreach (cells[k]) cells[k] = '0;
                end
                fwt2_pkg::REQ_ADD: begin
                    if (a >= n || b >= n) begin
                        res.oor = 1'b1;
                    end else begin
                        for (int i = a; i < n; i = i | (i + 1))
                            for (int j = b; j < n; j = j | (j + 1))
                                cells[i*GRID_MAX + j] += v;
                    end
                    sum_pending_q.push_back(res);
                end
                fwt2_pkg::REQ_QUERY: begin
                    if (a >= n || b >= n || c >= n || d >= n) begin
                        res.oor = 1'b1;
                    end else begin
                        res.sum = prefix_total(c, d) - prefix_total(a - 1, d)
                                - prefix_total(c, b - 1) + prefix_total(a - 1, b - 1);
                    end
                    sum_pending_q.push_back(res);
                end
                default: ;  // unused code: no effect, no result
            endcase
        endfunction

        // Compare one output transfer against the oldest prediction
        function void check_result(logic [DATA_W-1:0] sum, logic oor);
            t_rect_result want;
            if (sum_pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result rect_sum=%0d out_of_range=%b",
                         $time, $signed(sum), oor);
                return;
            end
            want = sum_pending_q.pop_front();
            if (sum !== want.sum) begin
                errors++;
                $display("%0t: rect_sum expected %0d, actual %0d",
                         $time, $signed(want.sum), $signed(sum));
            end
            if (oor !== want.oor) begin
                errors++;
                $display("%0t: out_of_range expected %b, actual %b",
                         $time, want.oor, oor);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     o_in_ready;
    logic [REQ_W-1:0]         req_type;
    logic [IDX_W-1:0]         row_lo;
    logic [IDX_W-1:0]         col_lo;
    logic [IDX_W-1:0]         row_hi;
    logic [IDX_W-1:0]         col_hi;
    logic signed [DATA_W-1:0] add_value;
    logic                     o_out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] o_rect_sum;
    logic                     o_out_of_range;
    logic                     cfg_we;
    logic [SIZE_W-1:0]        cfg_wdata;

    rect_sum_scoreboard board = new();
    int tx_max_gap = 14;
    int rx_max_gap = 14;
    int items_sent = 0;
    bit hold_rx    = 1'b0;

    fenwick_tree_2d_rect_sum #(
        .MAX_SIDE(GRID_MAX)
    ) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (req_type),
        .i_row_lo      (row_lo),
        .i_col_lo      (col_lo),
        .i_row_hi      (row_hi),
        .i_col_hi      (col_hi),
        .i_add_value   (add_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_rect_sum    (o_rect_sum),
        .o_out_of_range(o_out_of_range),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run time
    initial begin
        #25_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Result monitor: one check per output transfer
    always @(posedge clk) begin
        if (rst_n === 1'b1 && o_out_valid === 1'b1 && out_ready === 1'b1)
            board.check_result(o_rect_sum, o_out_of_range);
    end

    // Receiver: random ready gaps, plus one long hold-off on request
    initial begin
        int gap;
        out_ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            gap = $urandom_range(0, rx_max_gap);
            if (hold_rx) begin
                hold_rx = 1'b0;
                gap     = LONG_HOLD;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(o_out_valid === 1'b1 && out_ready === 1'b1));
        end
    end

    // One input transfer, preceded by a random idle gap
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] r1,
                                input logic [IDX_W-1:0] c1, input logic [IDX_W-1:0] r2,
                                input logic [IDX_W-1:0] c2, input logic [DATA_W-1:0] v);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        row_lo    <= r1;
        col_lo    <= c1;
        row_hi    <= r2;
        col_hi    <= c2;
        add_value <= v;
        do @(posedge clk); while (!(in_valid === 1'b1 && o_in_ready === 1'b1));
        board.note_request(req, r1, c1, r2, c2, v);
        items_sent++;
    endtask

    // Drain all results, then allow for a clear still sweeping
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (CLEAR_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_size(v);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return DATA_W'($signed($urandom_range(0, 200)) - 100);
        if (roll < 8) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] idx_in(int n);
        return IDX_W'($urandom_range(0, n - 1));
    endfunction

    function automatic logic [IDX_W-1:0] idx_any();
        return IDX_W'($urandom_range(0, GRID_MAX - 1));
    endfunction

    // One random request: mostly adds and in-range queries
    task automatic send_random(input int n);
        int roll;
        logic [IDX_W-1:0] r1, c1, r2, c2, t;
        roll = $urandom_range(0, 199);
        if (roll < 2) begin
            send_request(fwt2_pkg::REQ_CLEAR, idx_any(), idx_any(), idx_any(), idx_any(),
                         $urandom);
        end else if (roll < 6) begin
            send_request(fwt2_pkg::REQ_UNUSED, idx_any(), idx_any(), idx_any(), idx_any(),
                         $urandom);
        end else if (roll < 96) begin
            r1 = idx_in(n);
            c1 = idx_in(n);
            if (n < GRID_MAX && $urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 1) r1 = IDX_W'($urandom_range(n, GRID_MAX - 1));
                else                           c1 = IDX_W'($urandom_range(n, GRID_MAX - 1));
            end
            send_request(fwt2_pkg::REQ_ADD, r1, c1, idx_any(), idx_any(), pick_value());
        end else begin
            r1 = idx_in(n);
            c1 = idx_in(n);
            r2 = idx_in(n);
            c2 = idx_in(n);
            // keep most rectangles well-ordered, leave some reversed
            if ($urandom_range(0, 3) != 0) begin
                if (r1 > r2) begin t = r1; r1 = r2; r2 = t; end
                if (c1 > c2) begin t = c1; c1 = c2; c2 = t; end
            end
            if (n < GRID_MAX && $urandom_range(0, 9) == 0) begin
                t = IDX_W'($urandom_range(n, GRID_MAX - 1));
                case ($urandom_range(0, 3))
                    0:       r1 = t;
                    1:       c1 = t;
                    2:       r2 = t;
                    default: c2 = t;
                endcase
            end
            send_request(fwt2_pkg::REQ_QUERY, r1, c1, r2, c2, $urandom);
        end
    endtask

    // Matrix load: clear, then one add per cell
    task automatic load_grid(input int n);
        send_request(fwt2_pkg::REQ_CLEAR, '0, '0, '0, '0, '0);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_request(fwt2_pkg::REQ_ADD, IDX_W'(r), IDX_W'(c), idx_any(), idx_any(),
                             pick_value());
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] size, input int txg, input int rxg,
                             input bit pressure);
        int n, start;
        bit held, paused;
        held   = 1'b0;
        paused = 1'b0;
        wait_idle();
        write_size(size);
        tx_max_gap = txg;
        rx_max_gap = rxg;
        n     = board.side();
        start = items_sent;
        while (items_sent < start + PHASE_ITEMS) begin
            if (pressure && !held && items_sent >= start + 20) begin
                // receiver stalls while the sender keeps offering
                held    = 1'b1;
                hold_rx = 1'b1;
            end
            if (pressure && !paused && items_sent >= start + 80) begin
                // sender waits for every outstanding result
                paused   = 1'b1;
                in_valid <= 1'b0;
                do @(posedge clk); while (board.pending() != 0);
            end
            if (n <= 6 && $urandom_range(0, 29) == 0) load_grid(n);
            else                                     send_random(n);
        end
    endtask

    // Main sequence
    initial begin
        logic [SIZE_W-1:0] phase_size [NUM_PHASES];
        phase_size = '{7'd64, 7'd5, 7'd1, 7'd0, 7'd127, 7'd2,
                       7'd33, 7'd8, 7'd65, 7'd16, 7'd3, 7'd64};
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        req_type  <= fwt2_pkg::REQ_CLEAR;
        row_lo    <= '0;
        col_lo    <= '0;
        row_hi    <= '0;
        col_hi    <= '0;
        add_value <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // store sweep after reset: no transfer until ready
        do @(posedge clk); while (o_in_ready !== 1'b1);

        // Directed: reset size, corner cells and extreme values
        send_request(fwt2_pkg::REQ_ADD,    6'd0,  6'd0,  6'd0,  6'd0,  32'h7FFF_FFFF);
        send_request(fwt2_pkg::REQ_ADD,    6'd63, 6'd63, 6'd0,  6'd0,  32'h8000_0000);
        send_request(fwt2_pkg::REQ_ADD,    6'd0,  6'd63, 6'd0,  6'd0,  32'hFFFF_FFFF);
        send_request(fwt2_pkg::REQ_ADD,    6'd63, 6'd0,  6'd0,  6'd0,  32'h0000_0001);
        send_request(fwt2_pkg::REQ_ADD,    6'd31, 6'd32, 6'd63, 6'd63, 32'h5A5A_5A5A);
        send_request(fwt2_pkg::REQ_QUERY,  6'd0,  6'd0,  6'd63, 6'd63, 32'h0);
        send_request(fwt2_pkg::REQ_QUERY,  6'd63, 6'd63, 6'd63, 6'd63, 32'h0);
        send_request(fwt2_pkg::REQ_QUERY,  6'd0,  6'd0,  6'd0,  6'd0,  32'hFFFF_FFFF);
        send_request(fwt2_pkg::REQ_QUERY,  6'd40, 6'd50, 6'd10, 6'd5,  32'h0);
        send_request(fwt2_pkg::REQ_UNUSED, 6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_request(fwt2_pkg::REQ_ADD,    6'd31, 6'd32, 6'd0,  6'd0,  32'hA5A5_A5A5);
        send_request(fwt2_pkg::REQ_QUERY,  6'd31, 6'd32, 6'd31, 6'd32, 32'h0);
        send_request(fwt2_pkg::REQ_CLEAR,  6'd0,  6'd0,  6'd0,  6'd0,  32'h0);
        send_request(fwt2_pkg::REQ_QUERY,  6'd0,  6'd0,  6'd63, 6'd63, 32'h0);

        // Directed: small grid, out-of-range indices and reversed rectangle
        wait_idle();
        write_size(7'd8);
        send_request(fwt2_pkg::REQ_ADD,   6'd7,  6'd7,  6'd0, 6'd0,  32'd5);
        send_request(fwt2_pkg::REQ_ADD,   6'd8,  6'd0,  6'd0, 6'd0,  32'd9);
        send_request(fwt2_pkg::REQ_ADD,   6'd0,  6'd63, 6'd0, 6'd0,  32'd9);
        send_request(fwt2_pkg::REQ_QUERY, 6'd0,  6'd0,  6'd7, 6'd7,  32'h0);
        send_request(fwt2_pkg::REQ_QUERY, 6'd0,  6'd0,  6'd8, 6'd3,  32'h0);
        send_request(fwt2_pkg::REQ_QUERY, 6'd0,  6'd0,  6'd3, 6'd63, 32'h0);
        send_request(fwt2_pkg::REQ_QUERY, 6'd63, 6'd0,  6'd0, 6'd0,  32'h0);
        send_request(fwt2_pkg::REQ_QUERY, 6'd7,  6'd7,  6'd0, 6'd0,  32'h0);

        // Random phases over several sizes and idle patterns
        for (int k = 0; k < NUM_PHASES; k++)
            run_phase(phase_size[k], (k % 4 < 2) ? 14 : 0, (k % 2 == 0) ? 14 : 0, k == 0);

        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (CLEAR_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
